@@ design/uart_command_frame_recognizer_macros.svh @@
// Assertion macros shared by the command frame recognizer.
`ifndef UART_COMMAND_FRAME_RECOGNIZER_MACROS_SVH
`define UART_COMMAND_FRAME_RECOGNIZER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define UCFR_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define UCFR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ucfr_pkg.sv @@
// Types and constants of the command frame recognizer.
`default_nettype none

package ucfr_pkg;

    // Frame buffer size and derived widths
    localparam int FRAME_BUFFER_BYTES = 32;
    localparam int BYTE_W             = 8;
    localparam int HEAD_DEPTH         = 8;
    localparam int HEAD_IDX_W         = $clog2(HEAD_DEPTH);
    localparam int FILL_W             = $clog2(FRAME_BUFFER_BYTES + 1);
    localparam int LEN_W              = 6;
    localparam int KIND_W             = 2;
    localparam int MIN_CLOSE_LEN      = 8;

    // Fill levels in the fill counter width
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(FRAME_BUFFER_BYTES);
    localparam logic [FILL_W-1:0] FILL_HEAD  = FILL_W'(HEAD_DEPTH);
    localparam logic [FILL_W-1:0] FILL_CLOSE = FILL_W'(MIN_CLOSE_LEN);
    localparam logic [FILL_W-1:0] FILL_START = FILL_W'(2);

    // Framing bytes
    localparam logic [BYTE_W-1:0] BYTE_START0 = 8'hA5;
    localparam logic [BYTE_W-1:0] BYTE_START1 = 8'hFA;
    localparam logic [BYTE_W-1:0] BYTE_END    = 8'hFB;

    // Bytes 2..7 of the known commands, byte 2 in the top bits
    localparam logic [6*BYTE_W-1:0] PAT_HANDSHAKE = 48'h00_82_01_00_20_FB;
    localparam logic [6*BYTE_W-1:0] PAT_WAKE      = 48'h00_81_01_00_21_FB;
    localparam logic [6*BYTE_W-1:0] PAT_KEY       = 48'h00_82_01_00_0A_FB;

    typedef enum logic [KIND_W-1:0] {
        KIND_HANDSHAKE = 2'd0,
        KIND_WAKE      = 2'd1,
        KIND_KEY       = 2'd2,
        KIND_UNKNOWN   = 2'd3
    } t_frame_kind;

    typedef logic [HEAD_DEPTH-1:0][BYTE_W-1:0] t_head;

    // Frame state seen from outside the core
    typedef struct packed {
        logic              in_frame;
        logic              held;
        logic [FILL_W-1:0] fill;
    } t_status;

endpackage

`default_nettype wire

@@ design/ucfr_if.sv @@
// Request channels of the command frame recognizer.
`default_nettype none

interface ucfr_byte_if;
    logic                          valid;
    logic                          ready;
    logic [ucfr_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfr_result_if;
    logic                          valid;
    logic                          ready;
    logic [ucfr_pkg::KIND_W-1:0]   frame_kind;
    logic [ucfr_pkg::LEN_W-1:0]    frame_length;

    modport source (output valid, output frame_kind, output frame_length, input ready);
    modport sink   (input valid, input frame_kind, input frame_length, output ready);
endinterface

`default_nettype wire

@@ design/ucfr_in_reg.sv @@
// Input register for received bytes.
`default_nettype none

module ucfr_in_reg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    ucfr_byte_if.sink                        i_rx,
    input  wire logic                        i_take,
    output logic                             o_valid,
    output logic [ucfr_pkg::BYTE_W-1:0]      o_byte
);

    logic                        r_valid;
    logic [ucfr_pkg::BYTE_W-1:0] r_byte;

    // Accept when empty or when the held byte moves on this cycle
    assign i_rx.ready = !r_valid || i_take;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    // Load the byte on each accepted request
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

@@ design/ucfr_core.sv @@
// Frame state update, classification and result register.
`default_nettype none

module ucfr_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [ucfr_pkg::BYTE_W-1:0] i_byte,
    output logic                             o_take,
    ucfr_result_if.source                    o_res,
    output ucfr_pkg::t_status                o_status
);

    logic                                r_in_frame;
    logic                                r_held;
    logic [ucfr_pkg::FILL_W-1:0]         r_fill;
    ucfr_pkg::t_head                     r_head;
    logic                                r_out_valid;
    ucfr_pkg::t_frame_kind               r_kind;
    logic [ucfr_pkg::LEN_W-1:0]          r_len;

    logic                                n_in_frame;
    logic                                n_held;
    logic [ucfr_pkg::FILL_W-1:0]         n_fill;
    ucfr_pkg::t_head                     n_head;
    logic                                n_close;
    ucfr_pkg::t_frame_kind               n_kind;
    logic [ucfr_pkg::LEN_W-1:0]          n_len;

    logic [6*ucfr_pkg::BYTE_W-1:0]       w_body;

    // Advance one byte whenever the result register has room
    assign o_take = i_valid && (!r_out_valid || o_res.ready);

    // Process the held start byte, then the new byte
    always_comb begin
        n_in_frame = r_in_frame;
        n_held     = r_held;
        n_fill     = r_fill;
        n_head     = r_head;
        n_close    = 1'b0;
        n_kind     = ucfr_pkg::KIND_UNKNOWN;
        n_len      = '0;
        w_body     = '0;
        if (o_take) begin
            n_held = 1'b0;
            if (r_held && i_byte == ucfr_pkg::BYTE_START1) begin
                // Start pair: open or restart a frame
                n_in_frame = 1'b1;
                n_head[0]  = ucfr_pkg::BYTE_START0;
                n_head[1]  = ucfr_pkg::BYTE_START1;
                n_fill     = ucfr_pkg::FILL_START;
            end else begin
                // Release the held start byte as data
                if (r_held && r_in_frame && r_fill < ucfr_pkg::FILL_FULL) begin
                    if (r_fill < ucfr_pkg::FILL_HEAD) begin
                        n_head[r_fill[ucfr_pkg::HEAD_IDX_W-1:0]] = ucfr_pkg::BYTE_START0;
                    end
                    n_fill = r_fill + 1'b1;
                end
                if (i_byte == ucfr_pkg::BYTE_START0) begin
                    n_held = 1'b1;
                end else if (r_in_frame && n_fill < ucfr_pkg::FILL_FULL) begin
                    // Store the new byte and check for the end byte
                    if (n_fill < ucfr_pkg::FILL_HEAD) begin
                        n_head[n_fill[ucfr_pkg::HEAD_IDX_W-1:0]] = i_byte;
                    end
                    n_fill = n_fill + 1'b1;
                    if (i_byte == ucfr_pkg::BYTE_END && n_fill >= ucfr_pkg::FILL_CLOSE) begin
                        // Bytes 2..7 of the updated head, for pattern matching
                        w_body  = {n_head[2], n_head[3], n_head[4],
                                   n_head[5], n_head[6], n_head[7]};
                        n_close = 1'b1;
                        n_len   = ucfr_pkg::LEN_W'(n_fill);
                        if (n_fill != ucfr_pkg::FILL_CLOSE) begin
                            n_kind = ucfr_pkg::KIND_UNKNOWN;
                        end else if (w_body == ucfr_pkg::PAT_HANDSHAKE) begin
                            n_kind = ucfr_pkg::KIND_HANDSHAKE;
                        end else if (w_body == ucfr_pkg::PAT_WAKE) begin
                            n_kind = ucfr_pkg::KIND_WAKE;
                        end else if (w_body == ucfr_pkg::PAT_KEY) begin
                            n_kind = ucfr_pkg::KIND_KEY;
                        end else begin
                            n_kind = ucfr_pkg::KIND_UNKNOWN;
                        end
                        n_in_frame = 1'b0;
                        n_fill     = '0;
                    end
                end
            end
        end
    end

    // Frame control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_held     <= 1'b0;
            r_fill     <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_held     <= n_held;
            r_fill     <= n_fill;
        end
    end

    // Head bytes need no reset
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
    end

    // Result register: load on close, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_close) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_close) begin
            r_kind <= n_kind;
            r_len  <= n_len;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_kind   = r_kind;
    assign o_res.frame_length = r_len;

    assign o_status.in_frame = r_in_frame;
    assign o_status.held     = r_held;
    assign o_status.fill     = r_fill;

endmodule

`default_nettype wire

@@ design/uart_command_frame_recognizer.sv @@
// Command frame recognizer top level: input register, frame core, checks.
// Takes one received serial byte per request and returns one request per closed
// frame, carrying the frame kind (handshake, wake, key, unknown) and the frame
// length. Throughput is one byte per clock cycle while the result side accepts;
// the whole frame state (open flag, held A5, fill count, first eight bytes) is
// updated in a single cycle between the input register and the result register.
// The result register loads when the core takes the byte that closes a frame.
// The input side keeps accepting while a result waits, until both the input
// register and the result register are full. No clearing pass follows reset.
`default_nettype none
`include "uart_command_frame_recognizer_macros.svh"

module uart_command_frame_recognizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ucfr_byte_if.sink       i_rx,
    ucfr_result_if.source   o_res
);

    logic                        w_valid;
    logic [ucfr_pkg::BYTE_W-1:0] w_byte;
    logic                        w_take;
    ucfr_pkg::t_status           w_status;

    ucfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_byte  (w_byte)
    );

    ucfr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid),
        .i_byte   (w_byte),
        .o_take   (w_take),
        .o_res    (o_res),
        .o_status (w_status)
    );

    // A closed or never opened frame has an empty fill count
    `UCFR_ASSERT_SAME(a_idle_fill_empty, i_clk, i_rst_n,
        !w_status.in_frame, w_status.fill == '0,
        "fill count set outside a frame")

    // Only eight-byte frames match a known command
    `UCFR_ASSERT_SAME(a_known_len_eight, i_clk, i_rst_n,
        o_res.valid && o_res.frame_kind != ucfr_pkg::KIND_UNKNOWN,
        o_res.frame_length == ucfr_pkg::LEN_W'(ucfr_pkg::MIN_CLOSE_LEN),
        "known command with wrong length")

    // A start byte taken into the core is held for the next byte
    `UCFR_ASSERT_NEXT(a_start_held, i_clk, i_rst_n,
        w_take && w_byte == ucfr_pkg::BYTE_START0, w_status.held,
        "start byte not held")

endmodule

`default_nettype wire
